// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/gbc_pkg.sv
// types and constants of the gpio bank controller
`timescale 1ns / 1ps

package gbc_pkg;

	localparam int PINS_PER_WORD   = 10;
	localparam int FSEL_FIELD_BITS = 3;
	localparam int FSEL_WORDS      = 4;
	localparam int FSEL_WIDTH      = PINS_PER_WORD * FSEL_FIELD_BITS;
	localparam int BANK_PINS       = 32;

	localparam logic [2:0] FSEL_OUTPUT = 3'b001;

	localparam logic [5:0] ADDR_FSEL0   = 6'd0;
	localparam logic [5:0] ADDR_FSEL1   = 6'd1;
	localparam logic [5:0] ADDR_FSEL2   = 6'd2;
	localparam logic [5:0] ADDR_FSEL3   = 6'd3;
	localparam logic [5:0] ADDR_SET     = 6'd7;
	localparam logic [5:0] ADDR_CLEAR   = 6'd10;
	localparam logic [5:0] ADDR_LEVEL   = 6'd13;
	localparam logic [5:0] ADDR_PULL    = 6'd37;
	localparam logic [5:0] ADDR_PULLCLK = 6'd38;

	localparam logic ACTION_READ  = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	localparam logic [1:0] PULL_DOWN_CODE = 2'd1;
	localparam logic [1:0] PULL_UP_CODE   = 2'd2;

	typedef struct packed {
		logic        action;
		logic [5:0]  word_address;
		logic [31:0] write_data;
		logic [31:0] pad_levels;
	} gbc_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] drive_levels;
		logic [31:0] drive_enable;
		logic [31:0] pull_up_pins;
		logic [31:0] pull_down_pins;
		logic        bad_address;
	} gbc_rsp_t;

endpackage

// File: src/gpio_bank_controller_unit.sv
// top level of the gpio bank controller
`timescale 1ns / 1ps

// usage
// req channel: one bus access per word (read or write, word address, write
// data and the sampled pad levels), taken when req_valid is high and req_stall low
// rsp channel: one word per access with the read data, the output latch, the
// drive enables, the pull-up and pull-down pins and the bad address flag,
// all as they stand after the access
// pipeline: an access is registered at the input, then applied to the bank
// registers and its response registered in the second stage
// throughput: one access per cycle while the response is not stalled, set by
// the single read-modify-write of the bank registers in the second stage
// reset: all pins inputs, latch and pull settings zero, both stages empty
// a stalled response holds; the input register keeps one more access, and
// req_stall rises only when both stages are full and the response is stalled

module gpio_bank_controller_unit
	import gbc_pkg::*;
#(
	parameter int PIN_COUNT = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  gbc_req_t req_word,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output gbc_rsp_t rsp_word
);

	logic                  valid_s1;
	gbc_req_t              req_s1;
	logic                  valid_s2;
	gbc_rsp_t              rsp_s2;
	logic                  load_s2;
	logic                  load_s1;

	logic [FSEL_WIDTH-1:0] fsel_q [FSEL_WORDS];
	logic [31:0]           latch_q;
	logic [1:0]            pull_ctl_q;
	logic [1:0]            pin_pull_q [BANK_PINS];

	logic [FSEL_WIDTH-1:0] fsel_d [FSEL_WORDS];
	logic [31:0]           latch_d;
	logic [1:0]            pull_ctl_d;
	logic [1:0]            pin_pull_d [BANK_PINS];
	logic [31:0]           pin_mask;
	logic [31:0]           en_cur;
	gbc_rsp_t              rsp_d;

	function automatic logic [FSEL_WIDTH-1:0] fsel_mask(input logic [1:0] w);
		logic [FSEL_WIDTH-1:0] m;
		m = '0;
		for (int k = 0; k < PINS_PER_WORD; k++) begin
			if (int'(w) * PINS_PER_WORD + k < PIN_COUNT) begin
				m[k*FSEL_FIELD_BITS +: FSEL_FIELD_BITS] = '1;
			end
		end
		return m;
	endfunction

	assign load_s2   = !valid_s2 || !rsp_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign req_stall = !load_s1;
	assign rsp_valid = valid_s2;
	assign rsp_word  = rsp_s2;

	always_comb begin
		for (int p = 0; p < BANK_PINS; p++) begin
			pin_mask[p] = (p < PIN_COUNT);
			en_cur[p]   = (p < PIN_COUNT) &&
				(fsel_q[p/PINS_PER_WORD][(p%PINS_PER_WORD)*FSEL_FIELD_BITS +: FSEL_FIELD_BITS]
				== FSEL_OUTPUT);
		end
	end

	always_comb begin
		fsel_d     = fsel_q;
		latch_d    = latch_q;
		pull_ctl_d = pull_ctl_q;
		pin_pull_d = pin_pull_q;
		rsp_d      = '0;
		case (req_s1.word_address)
			ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2, ADDR_FSEL3: begin
				if (req_s1.action == ACTION_WRITE) begin
					fsel_d[req_s1.word_address[1:0]] = req_s1.write_data[FSEL_WIDTH-1:0] &
						fsel_mask(req_s1.word_address[1:0]);
				end else begin
					rsp_d.read_data = 32'(fsel_q[req_s1.word_address[1:0]]);
				end
			end
			ADDR_SET: begin
				if (req_s1.action == ACTION_WRITE) begin
					latch_d = latch_q | (req_s1.write_data & pin_mask);
				end
			end
			ADDR_CLEAR: begin
				if (req_s1.action == ACTION_WRITE) begin
					latch_d = latch_q & ~(req_s1.write_data & pin_mask);
				end
			end
			ADDR_LEVEL: begin
				if (req_s1.action == ACTION_READ) begin
					rsp_d.read_data = ((latch_q & en_cur) | (req_s1.pad_levels & ~en_cur)) &
						pin_mask;
				end
			end
			ADDR_PULL: begin
				if (req_s1.action == ACTION_WRITE) begin
					pull_ctl_d = req_s1.write_data[1:0];
				end else begin
					rsp_d.read_data = {30'd0, pull_ctl_q};
				end
			end
			ADDR_PULLCLK: begin
				if (req_s1.action == ACTION_WRITE) begin
					for (int p = 0; p < BANK_PINS; p++) begin
						if (p < PIN_COUNT && req_s1.write_data[p]) begin
							pin_pull_d[p] = pull_ctl_q;
						end
					end
				end
			end
			default: begin
				rsp_d.bad_address = 1'b1;
			end
		endcase

		rsp_d.drive_levels = latch_d;
		for (int p = 0; p < BANK_PINS; p++) begin
			rsp_d.drive_enable[p] = (p < PIN_COUNT) &&
				(fsel_d[p/PINS_PER_WORD][(p%PINS_PER_WORD)*FSEL_FIELD_BITS +: FSEL_FIELD_BITS]
				== FSEL_OUTPUT);
			rsp_d.pull_up_pins[p]   = (pin_pull_d[p] == PULL_UP_CODE);
			rsp_d.pull_down_pins[p] = (pin_pull_d[p] == PULL_DOWN_CODE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			fsel_q     <= '{default: '0};
			latch_q    <= '0;
			pull_ctl_q <= '0;
			pin_pull_q <= '{default: '0};
		end else begin
			if (load_s1) begin
				valid_s1 <= req_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2 && valid_s1) begin
				fsel_q     <= fsel_d;
				latch_q    <= latch_d;
				pull_ctl_q <= pull_ctl_d;
				pin_pull_q <= pin_pull_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			req_s1 <= req_word;
		end
		if (load_s2 && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule

// File: src/gpio_bank_controller_checker.sv
// port checker of the gpio bank controller and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpio_bank_controller_checker
	import gbc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input gbc_req_t req_word,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input gbc_rsp_t rsp_word
);

	`ASSERT_ALWAYS(rsp_empty_in_reset, !arst_n |-> !rsp_valid, "response valid during reset")
	`ASSERT_ON(rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word),
		"stalled word changed")
	`ASSERT_ON(pull_disjoint,
		rsp_valid |-> ((rsp_word.pull_up_pins & rsp_word.pull_down_pins) == '0),
		"pin pulled both ways")
	`ASSERT_ON(bad_reads_zero, rsp_valid && rsp_word.bad_address |-> (rsp_word.read_data == '0),
		"bad address returned data")

endmodule

bind gpio_bank_controller_unit gpio_bank_controller_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_word  (req_word),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);
